// ===== hdl/hrsp_pkg.sv =====
// hrsp_pkg: phase codes, class/event/error codes and match helpers
// for the http request stream parser; depends on nothing
package hrsp_pkg;

  localparam logic [3:0] PH_VERB_SEEK  = 4'd0;
  localparam logic [3:0] PH_VERB       = 4'd1;
  localparam logic [3:0] PH_ROUTE_SEEK = 4'd2;
  localparam logic [3:0] PH_ROUTE      = 4'd3;
  localparam logic [3:0] PH_MARKER     = 4'd4;
  localparam logic [3:0] PH_VERSION    = 4'd5;
  localparam logic [3:0] PH_LINE_END   = 4'd6;
  localparam logic [3:0] PH_HDR_START  = 4'd7;
  localparam logic [3:0] PH_HDR_NAME   = 4'd8;
  localparam logic [3:0] PH_HDR_VALUE  = 4'd9;
  localparam logic [3:0] PH_BODY_LEN   = 4'd10;
  localparam logic [3:0] PH_CH_SKIP    = 4'd11;
  localparam logic [3:0] PH_CH_SIZE    = 4'd12;
  localparam logic [3:0] PH_CH_LF      = 4'd13;
  localparam logic [3:0] PH_CH_DATA    = 4'd14;
  localparam logic [3:0] PH_CH_TRAIL   = 4'd15;

  localparam logic [2:0] CL_SKIP    = 3'd0;
  localparam logic [2:0] CL_VERB    = 3'd1;
  localparam logic [2:0] CL_ROUTE   = 3'd2;
  localparam logic [2:0] CL_VERSION = 3'd3;
  localparam logic [2:0] CL_NAME    = 3'd4;
  localparam logic [2:0] CL_VALUE   = 3'd5;
  localparam logic [2:0] CL_BODY    = 3'd6;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_LINE_DONE = 3'd1;
  localparam logic [2:0] EV_NAME      = 3'd2;
  localparam logic [2:0] EV_HDR_DONE  = 3'd3;
  localparam logic [2:0] EV_HDRS_END  = 3'd4;
  localparam logic [2:0] EV_SIZE      = 3'd5;
  localparam logic [2:0] EV_CHUNK     = 3'd6;

  localparam logic [1:0] ER_NONE    = 2'd0;
  localparam logic [1:0] ER_BAD_HEX = 2'd1;
  localparam logic [1:0] ER_OVERFLOW = 2'd2;
  localparam logic [1:0] ER_BAD_DEC = 2'd3;

  localparam logic [4:0] FL_DELIM   = 5'd1;
  localparam logic [4:0] FL_STARTED = 5'd2;
  localparam logic [4:0] FL_ENDED   = 5'd4;
  localparam logic [4:0] FL_ACC     = 5'd8;
  localparam logic [4:0] FL_STOPPED = 5'd16;

  localparam logic [1:0] LM_CHUNKED = 2'd0;
  localparam logic [1:0] LM_LENGTH  = 2'd1;

  // header name code that frames the body by length
  localparam logic [2:0] FD_CONTENT_LENGTH = 3'd2;

  typedef logic [7:0] char_t;

  function automatic logic is_ws(input char_t c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  // returns {valid, value}
  function automatic logic [4:0] hex_val(input char_t c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") r = {1'b1, c[3:0]};
    else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  function automatic char_t verb_char(input int i, input logic [4:0] p);
    char_t r;
    r = 8'h00;
    case (i)
      0: case (p) 0: r = "G"; 1: r = "E"; 2: r = "T"; default: r = 8'h00; endcase
      1: case (p) 0: r = "P"; 1: r = "O"; 2: r = "S"; 3: r = "T"; default: r = 8'h00; endcase
      2: case (p) 0: r = "P"; 1: r = "A"; 2: r = "T"; 3: r = "C"; 4: r = "H";
        default: r = 8'h00; endcase
      3: case (p) 0: r = "P"; 1: r = "U"; 2: r = "T"; default: r = 8'h00; endcase
      4: case (p) 0: r = "T"; 1: r = "R"; 2: r = "A"; 3: r = "C"; 4: r = "E";
        default: r = 8'h00; endcase
      5: case (p) 0: r = "D"; 1: r = "E"; 2: r = "L"; 3: r = "E"; 4: r = "T"; 5: r = "E";
        default: r = 8'h00; endcase
      6: case (p) 0: r = "C"; 1: r = "O"; 2: r = "N"; 3: r = "N"; 4: r = "E"; 5: r = "C";
        6: r = "T"; default: r = 8'h00; endcase
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] verb_len(input int i);
    logic [4:0] r;
    case (i)
      0: r = 5'd3; 1: r = 5'd4; 2: r = 5'd5; 3: r = 5'd3;
      4: r = 5'd5; 5: r = 5'd6; 6: r = 5'd7; default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic char_t ver_char(input int i, input logic [4:0] p);
    char_t r;
    r = 8'h00;
    case (i)
      0: case (p) 0: r = "0"; 1: r = "."; 2: r = "9"; default: r = 8'h00; endcase
      1: case (p) 0: r = "1"; 1: r = "."; 2: r = "0"; default: r = 8'h00; endcase
      2: case (p) 0: r = "1"; 1: r = "."; 2: r = "1"; default: r = 8'h00; endcase
      3: r = (p == 5'd0) ? "2" : 8'h00;
      4: r = (p == 5'd0) ? "3" : 8'h00;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] ver_len(input int i);
    return (i < 3) ? 5'd3 : 5'd1;
  endfunction

  function automatic char_t name_char(input int i, input logic [4:0] p);
    logic [8*17-1:0] s;
    logic [4:0] n;
    char_t r;
    case (i)
      0: begin s = {"CONTENT-TYPE", 40'h0}; n = 5'd12; end
      1: begin s = {"CONTENT-LENGTH", 24'h0}; n = 5'd14; end
      2: begin s = {"ACCEPT", 88'h0}; n = 5'd6; end
      3: begin s = {"HOST", 104'h0}; n = 5'd4; end
      4: begin s = "TRANSFER-ENCODING"; n = 5'd17; end
      default: begin s = {"CONNECTION", 56'h0}; n = 5'd10; end
    endcase
    r = 8'h00;
    if (p < n) r = s[8*(16-p) +: 8];
    return r;
  endfunction

  function automatic logic [4:0] name_len(input int i);
    logic [4:0] r;
    case (i)
      0: r = 5'd12; 1: r = 5'd14; 2: r = 5'd6; 3: r = 5'd4;
      4: r = 5'd17; 5: r = 5'd10; default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/http_request_stream_parser_unit.sv =====
// http_request_stream_parser_unit: byte-serial http/1.x request parser top level
// depends on hrsp_pkg (codes and match tables)
//
// usage:
//   in_valid/in_ready/in_byte carries one byte of the request stream per request.
//   out_valid/out_ready carries one result per byte: the byte itself, its class,
//   an event code, the held verb/version/header codes, the body length and
//   request_done / error_code flags.
//   every byte is parsed by shallow logic in the cycle it is taken; the
//   result is registered in the output register.
//   throughput is one byte per clock: a new byte is taken whenever the
//   output register is empty or is being drained in the same cycle.
//   if the receiver stalls, out_* hold and in_ready drops, so at most one
//   result waits; nothing is lost or repeated.
//   synchronous active-low reset puts the parser at the start of a request
//   line and empties the output register.
//   after a completed request or any error the parser restarts by itself.
module http_request_stream_parser_unit #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [2:0]  out_byte_class,
  output logic [2:0]  out_event_code,
  output logic [2:0]  out_method_code,
  output logic [2:0]  out_protocol_version,
  output logic [2:0]  out_field_code,
  output logic [31:0] out_body_length,
  output logic        out_request_done,
  output logic [1:0]  out_error_code
);

  localparam int LB = LENGTH_BITS;
  // width of product/sum before overflow check
  localparam int WB = LENGTH_BITS + 4;
  localparam logic [WB-1:0] LEN_MAX = {4'd0, {LB{1'b1}}};

  // parser state
  logic [3:0]    phase_r, phase_nxt;
  logic [4:0]    pos_r, pos_nxt;
  logic [6:0]    mcand_r, mcand_nxt;
  logic [4:0]    vcand_r, vcand_nxt;
  logic [5:0]    fcand_r, fcand_nxt;
  logic [2:0]    mstep_r, mstep_nxt;
  logic [2:0]    hmeth_r, hmeth_nxt;
  logic [2:0]    hver_r, hver_nxt;
  logic [2:0]    hfld_r, hfld_nxt;
  logic [4:0]    flags_r, flags_nxt;
  logic [1:0]    lmode_r, lmode_nxt;
  logic [LB-1:0] acc_r, acc_nxt;
  logic [LB-1:0] rcv_r, rcv_nxt;

  // output register
  logic        ovalid_r;
  logic [7:0]  obyte_r;
  logic [2:0]  ocls_r, oev_r, ometh_r, over_r, ofld_r;
  logic [31:0] olen_r;
  logic        odone_r;
  logic [1:0]  oerr_r;

  logic take;
  assign in_ready = !ovalid_r || out_ready;
  assign take     = in_valid && in_ready;

  logic [7:0]  c, cu;
  logic        ws;
  logic [2:0]  cls, ev;
  logic        done, restart;
  logic [1:0]  err;
  logic [4:0]  hx;
  logic [4:0]  pos_bump;
  logic [WB-1:0] dec_sum, hex_sum;
  logic        vbyte;
  logic [LB-1:0] rcv_inc;
  logic        mark_hit;

  // match helpers: narrowing masks at the current position and at position 0
  logic [6:0] mnarrow, mnarrow0;
  logic [4:0] vnarrow;
  logic [5:0] fnarrow, fnarrow0;
  logic [2:0] mfin, vfin, ffin;

  always_comb begin
    c  = in_byte;
    cu = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    for (int i = 0; i < 7; i++) begin
      mnarrow[i]  = mcand_r[i] && (pos_r < hrsp_pkg::verb_len(i)) &&
                    (hrsp_pkg::verb_char(i, pos_r) == c);
      mnarrow0[i] = hrsp_pkg::verb_char(i, 5'd0) == c;
    end
    for (int i = 0; i < 5; i++)
      vnarrow[i] = vcand_r[i] && (pos_r < hrsp_pkg::ver_len(i)) &&
                   (hrsp_pkg::ver_char(i, pos_r) == c);
    for (int i = 0; i < 6; i++) begin
      fnarrow[i]  = fcand_r[i] && (pos_r < hrsp_pkg::name_len(i)) &&
                    (hrsp_pkg::name_char(i, pos_r) == cu);
      fnarrow0[i] = hrsp_pkg::name_char(i, 5'd0) == cu;
    end
    // first match wins, so scan downward
    mfin = 3'd0;
    for (int i = 6; i >= 0; i--)
      if (mcand_r[i] && hrsp_pkg::verb_len(i) == pos_r) mfin = 3'(i + 1);
    vfin = 3'd0;
    for (int i = 4; i >= 0; i--)
      if (vcand_r[i] && hrsp_pkg::ver_len(i) == pos_r) vfin = 3'(i + 1);
    ffin = 3'd0;
    for (int i = 5; i >= 0; i--)
      if (fcand_r[i] && hrsp_pkg::name_len(i) == pos_r) ffin = 3'(i + 1);
  end

  always_comb begin
    ws       = hrsp_pkg::is_ws(c);
    hx       = hrsp_pkg::hex_val(c);
    pos_bump = (pos_r < 5'd31) ? pos_r + 5'd1 : pos_r;
    // acc*10+d and acc*16+d, with headroom to see overflow
    dec_sum  = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + WB'(c[3:0]);
    hex_sum  = ({4'd0, acc_r} << 4) + WB'(hx[3:0]);
    rcv_inc  = rcv_r + LB'(1);
    // scanning for "HTTP/"
    mark_hit = ((mstep_r == 3'd0) && c == "H") || ((mstep_r == 3'd1) && c == "T") ||
               ((mstep_r == 3'd2) && c == "T") || ((mstep_r == 3'd3) && c == "P") ||
               ((mstep_r == 3'd4) && c == "/");

    phase_nxt = phase_r;  pos_nxt = pos_r;  mcand_nxt = mcand_r;
    vcand_nxt = vcand_r;  fcand_nxt = fcand_r;  mstep_nxt = mstep_r;
    hmeth_nxt = hmeth_r;  hver_nxt = hver_r;  hfld_nxt = hfld_r;
    flags_nxt = flags_r;  lmode_nxt = lmode_r;  acc_nxt = acc_r;  rcv_nxt = rcv_r;
    cls = hrsp_pkg::CL_SKIP;  ev = hrsp_pkg::EV_NONE;
    done = 1'b0;  restart = 1'b0;  err = hrsp_pkg::ER_NONE;  vbyte = 1'b0;

    case (phase_r)
      hrsp_pkg::PH_VERB_SEEK: if (!ws) begin
        cls = hrsp_pkg::CL_VERB;  mcand_nxt = mnarrow0;
        pos_nxt = 5'd1;  phase_nxt = hrsp_pkg::PH_VERB;
      end
      hrsp_pkg::PH_VERB: if (!ws) begin
        cls = hrsp_pkg::CL_VERB;  mcand_nxt = mnarrow;  pos_nxt = pos_bump;
      end else begin
        hmeth_nxt = mfin;  phase_nxt = hrsp_pkg::PH_ROUTE_SEEK;
      end
      hrsp_pkg::PH_ROUTE_SEEK: if (!ws) begin
        cls = hrsp_pkg::CL_ROUTE;  phase_nxt = hrsp_pkg::PH_ROUTE;
      end
      hrsp_pkg::PH_ROUTE: if (!ws) cls = hrsp_pkg::CL_ROUTE;
      else begin
        phase_nxt = hrsp_pkg::PH_MARKER;  mstep_nxt = 3'd0;
      end
      hrsp_pkg::PH_MARKER: begin
        if (mark_hit && mstep_r == 3'd4) begin
          mstep_nxt = 3'd0;  phase_nxt = hrsp_pkg::PH_VERSION;
          pos_nxt = 5'd0;  vcand_nxt = 5'h1f;
        end else if (mark_hit) mstep_nxt = mstep_r + 3'd1;
        else mstep_nxt = (c == "H") ? 3'd1 : 3'd0;
      end
      hrsp_pkg::PH_VERSION: if (!ws) begin
        cls = hrsp_pkg::CL_VERSION;  vcand_nxt = vnarrow;  pos_nxt = pos_bump;
      end else begin
        hver_nxt = vfin;  phase_nxt = hrsp_pkg::PH_LINE_END;
      end
      hrsp_pkg::PH_LINE_END: if (c == 8'h0a) begin
        ev = hrsp_pkg::EV_LINE_DONE;  phase_nxt = hrsp_pkg::PH_HDR_START;
      end
      hrsp_pkg::PH_HDR_START: if (c == 8'h0a) begin
        rcv_nxt = '0;
        if (lmode_r == hrsp_pkg::LM_LENGTH) begin
          ev = hrsp_pkg::EV_SIZE;
          if (acc_r == '0) begin
            done = 1'b1;  restart = 1'b1;
          end else phase_nxt = hrsp_pkg::PH_BODY_LEN;
        end else begin
          ev = hrsp_pkg::EV_HDRS_END;  acc_nxt = '0;  flags_nxt = '0;
          phase_nxt = hrsp_pkg::PH_CH_SKIP;
        end
      end else if (!ws) begin
        cls = hrsp_pkg::CL_NAME;  fcand_nxt = fnarrow0;  pos_nxt = 5'd1;
        flags_nxt = '0;  phase_nxt = hrsp_pkg::PH_HDR_NAME;
      end
      hrsp_pkg::PH_HDR_NAME: if (!ws && c != ":") begin
        cls = hrsp_pkg::CL_NAME;  fcand_nxt = fnarrow;  pos_nxt = pos_bump;
      end else begin
        hfld_nxt = ffin;  ev = hrsp_pkg::EV_NAME;
        flags_nxt = (c == ":") ? hrsp_pkg::FL_DELIM : 5'd0;
        // content-length, first one only
        if (ffin == hrsp_pkg::FD_CONTENT_LENGTH && lmode_r == hrsp_pkg::LM_CHUNKED) begin
          lmode_nxt = hrsp_pkg::LM_LENGTH;
          flags_nxt = ((c == ":") ? hrsp_pkg::FL_DELIM : 5'd0) | hrsp_pkg::FL_ACC;
          acc_nxt = '0;
        end
        phase_nxt = hrsp_pkg::PH_HDR_VALUE;
      end
      hrsp_pkg::PH_HDR_VALUE: begin
        if ((flags_r & hrsp_pkg::FL_DELIM) == 5'd0 && c == ":")
          flags_nxt = flags_r | hrsp_pkg::FL_DELIM;
        else if (c == 8'h0a) begin
          ev = hrsp_pkg::EV_HDR_DONE;  phase_nxt = hrsp_pkg::PH_HDR_START;
        end else if (!ws && (flags_r & hrsp_pkg::FL_STARTED) == 5'd0) begin
          flags_nxt = flags_r | hrsp_pkg::FL_STARTED;  vbyte = 1'b1;
        end else if ((flags_r & hrsp_pkg::FL_STARTED) != 5'd0 &&
                     (flags_r & hrsp_pkg::FL_ENDED) == 5'd0) begin
          if (!ws || c == 8'h20 || c == 8'h09) vbyte = 1'b1;
          else flags_nxt = flags_r | hrsp_pkg::FL_ENDED;
        end
        if (vbyte) begin
          cls = hrsp_pkg::CL_VALUE;
          if ((flags_r & hrsp_pkg::FL_ACC) != 5'd0) begin
            if (c >= "0" && c <= "9") begin
              if (dec_sum > LEN_MAX) err = hrsp_pkg::ER_OVERFLOW;
              else acc_nxt = dec_sum[LB-1:0];
            end else err = hrsp_pkg::ER_BAD_DEC;
          end
        end
      end
      hrsp_pkg::PH_BODY_LEN: begin
        cls = hrsp_pkg::CL_BODY;  rcv_nxt = rcv_inc;
        if (rcv_inc >= acc_r) begin
          done = 1'b1;  restart = 1'b1;
        end
      end
      hrsp_pkg::PH_CH_SKIP: if (!ws) begin
        if (!hx[4]) err = hrsp_pkg::ER_BAD_HEX;
        else begin
          acc_nxt = LB'(hx[3:0]);  flags_nxt = '0;  phase_nxt = hrsp_pkg::PH_CH_SIZE;
        end
      end
      hrsp_pkg::PH_CH_SIZE: if (!ws) begin
        if ((flags_r & hrsp_pkg::FL_STOPPED) == 5'd0) begin
          if (!hx[4]) flags_nxt = flags_r | hrsp_pkg::FL_STOPPED;
          else if (hex_sum > LEN_MAX) err = hrsp_pkg::ER_OVERFLOW;
          else acc_nxt = hex_sum[LB-1:0];
        end
      end else begin
        ev = hrsp_pkg::EV_SIZE;  rcv_nxt = '0;  phase_nxt = hrsp_pkg::PH_CH_LF;
      end
      hrsp_pkg::PH_CH_LF: if (c == 8'h0a)
        phase_nxt = (acc_r == '0) ? hrsp_pkg::PH_CH_TRAIL : hrsp_pkg::PH_CH_DATA;
      hrsp_pkg::PH_CH_DATA: begin
        cls = hrsp_pkg::CL_BODY;  rcv_nxt = rcv_inc;
        if (rcv_inc >= acc_r) phase_nxt = hrsp_pkg::PH_CH_TRAIL;
      end
      hrsp_pkg::PH_CH_TRAIL: if (c == 8'h0a) begin
        ev = hrsp_pkg::EV_CHUNK;
        if (acc_r == '0) begin
          done = 1'b1;  restart = 1'b1;
        end else begin
          acc_nxt = '0;  rcv_nxt = '0;  flags_nxt = '0;  phase_nxt = hrsp_pkg::PH_CH_SKIP;
        end
      end
      default: restart = 1'b1;
    endcase

    if (err != hrsp_pkg::ER_NONE) begin
      cls = hrsp_pkg::CL_SKIP;  ev = hrsp_pkg::EV_NONE;  restart = 1'b1;
    end
  end

  // parser state: reset and self-restart go to the start of a request
  always_ff @(posedge clk) begin
    if (!rst_n || (take && restart)) begin
      phase_r <= hrsp_pkg::PH_VERB_SEEK;  pos_r <= '0;
      mcand_r <= 7'h7f;  vcand_r <= 5'h1f;  fcand_r <= 6'h3f;
      mstep_r <= '0;  hmeth_r <= '0;  hver_r <= '0;  hfld_r <= '0;
      flags_r <= '0;  lmode_r <= hrsp_pkg::LM_CHUNKED;  acc_r <= '0;  rcv_r <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;  pos_r <= pos_nxt;
      mcand_r <= mcand_nxt;  vcand_r <= vcand_nxt;  fcand_r <= fcand_nxt;
      mstep_r <= mstep_nxt;  hmeth_r <= hmeth_nxt;  hver_r <= hver_nxt;
      hfld_r <= hfld_nxt;  flags_r <= flags_nxt;  lmode_r <= lmode_nxt;
      acc_r <= acc_nxt;  rcv_r <= rcv_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (take) ovalid_r <= 1'b1;
    else if (out_ready) ovalid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      obyte_r <= c;  ocls_r <= cls;  oev_r <= ev;
      ometh_r <= hmeth_nxt;  over_r <= hver_nxt;  ofld_r <= hfld_nxt;
      olen_r  <= 32'(acc_nxt);
      odone_r <= done;  oerr_r <= err;
    end
  end

  assign out_valid            = ovalid_r;
  assign out_byte             = obyte_r;
  assign out_byte_class       = ocls_r;
  assign out_event_code       = oev_r;
  assign out_method_code      = ometh_r;
  assign out_protocol_version = over_r;
  assign out_field_code       = ofld_r;
  assign out_body_length      = olen_r;
  assign out_request_done     = odone_r;
  assign out_error_code       = oerr_r;

endmodule

// ===== hdl/hrsp_checker.sv =====
// hrsp_checker: port-level checks for http_request_stream_parser_unit
// depends on hrsp_pkg; bound to the top level below
module hrsp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [2:0] out_byte_class,
  input logic [2:0] out_event_code,
  input logic       out_request_done,
  input logic [1:0] out_error_code
);

  // an accepted request shows up as a result on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid && out_byte == $past(in_byte))
    else $error("result missing after request");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("stalled result changed");

  // errors carry no class, no event and no request done
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != hrsp_pkg::ER_NONE |->
      out_byte_class == hrsp_pkg::CL_SKIP && out_event_code == hrsp_pkg::EV_NONE &&
      !out_request_done)
    else $error("error result with class or event");

  // done comes only with a body byte, size event or chunk event
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_request_done |->
      out_byte_class == hrsp_pkg::CL_BODY || out_event_code == hrsp_pkg::EV_SIZE ||
      out_event_code == hrsp_pkg::EV_CHUNK)
    else $error("request done on unexpected byte");

endmodule

bind http_request_stream_parser_unit hrsp_checker u_hrsp_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_byte(in_byte), .out_valid(out_valid), .out_ready(out_ready),
  .out_byte(out_byte), .out_byte_class(out_byte_class),
  .out_event_code(out_event_code), .out_request_done(out_request_done),
  .out_error_code(out_error_code)
);

// ===== test/tb.sv =====
// tb: self-checking bench for http_request_stream_parser_unit
// depends on hrsp_pkg and the parser top level; predicts every result per request byte
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    logic [7:0]  b;
    logic [2:0]  cls;
    logic [2:0]  ev;
    logic [2:0]  meth;
    logic [2:0]  ver;
    logic [2:0]  fld;
    logic [31:0] len;
    logic        done;
    logic [1:0]  err;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic [2:0]  out_byte_class, out_event_code, out_method_code;
  logic [2:0]  out_protocol_version, out_field_code;
  logic [31:0] out_body_length;
  logic        out_request_done;
  logic [1:0]  out_error_code;

  http_request_stream_parser_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .out_byte_class(out_byte_class), .out_event_code(out_event_code),
    .out_method_code(out_method_code), .out_protocol_version(out_protocol_version),
    .out_field_code(out_field_code), .out_body_length(out_body_length),
    .out_request_done(out_request_done), .out_error_code(out_error_code)
  );

  always #5 clk = ~clk;

  // parser state mirror
  localparam logic [63:0] SIZE_MAX = 64'hFFFF_FFFF;
  logic [3:0]  phase;
  logic [4:0]  tok_pos;
  logic [6:0]  verb_cand;
  logic [6:0]  ver_cand;
  logic [6:0]  name_cand;
  logic [2:0]  mark_pos;
  logic [2:0]  cur_verb, cur_ver, cur_name;
  logic [4:0]  hdr_flags;
  logic [1:0]  frame_mode;
  logic [63:0] size_acc;
  logic [63:0] body_cnt;

  parse_result_t result_q[$];
  byte unsigned  stream_q[$];

  int  mismatches = 0;
  bit  failed = 1'b0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  rx_gap = 0;
  int  bytes_sent = 0;

  // match tables: kind 0 verbs, 1 versions, 2 header names
  function automatic string word(input int kind, input int i);
    string verbs[7] = '{"GET", "POST", "PATCH", "PUT", "TRACE", "DELETE", "CONNECT"};
    string vers[5]  = '{"0.9", "1.0", "1.1", "2", "3"};
    string names[6] = '{"CONTENT-TYPE", "CONTENT-LENGTH", "ACCEPT", "HOST",
                        "TRANSFER-ENCODING", "CONNECTION"};
    if (kind == 0) return verbs[i];
    if (kind == 1) return vers[i];
    return names[i];
  endfunction

  function automatic logic [6:0] narrow_cand(input int kind, input int n,
                                             input logic [6:0] cand, input logic [4:0] pos,
                                             input logic [7:0] c);
    string w;
    for (int i = 0; i < n; i++) begin
      w = word(kind, i);
      if (cand[i] && (pos >= w.len() || w[pos] != c)) cand[i] = 1'b0;
    end
    return cand;
  endfunction

  function automatic logic [2:0] pick_code(input int kind, input int n,
                                           input logic [6:0] cand, input logic [4:0] pos);
    string w;
    for (int i = 0; i < n; i++) begin
      w = word(kind, i);
      if (cand[i] && w.len() == pos) return 3'(i + 1);
    end
    return 3'd0;
  endfunction

  function automatic bit blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  task automatic restart_parser();
    phase = hrsp_pkg::PH_VERB_SEEK;
    tok_pos = 0;
    verb_cand = 7'h7f;
    ver_cand = 7'h1f;
    name_cand = 7'h3f;
    mark_pos = 0;
    cur_verb = 0;
    cur_ver = 0;
    cur_name = 0;
    hdr_flags = 0;
    frame_mode = hrsp_pkg::LM_CHUNKED;
    size_acc = 0;
    body_cnt = 0;
  endtask

  // append one byte to the outgoing stream
  task automatic add_byte(input byte unsigned b);
    stream_q = {stream_q, b};
  endtask

  // advance the mirror by one request byte and queue the expected result
  task automatic parse_byte(input logic [7:0] c);
    parse_result_t r;
    bit ws, restart, take;
    logic [7:0] up;
    string mark;
    int d;
    ws = blank(c);
    restart = 0;
    take = 0;
    mark = "HTTP/";
    up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    r = '0;
    r.cls = hrsp_pkg::CL_SKIP;
    r.ev = hrsp_pkg::EV_NONE;
    r.err = hrsp_pkg::ER_NONE;
    case (phase)
      hrsp_pkg::PH_VERB_SEEK: if (!ws) begin
        r.cls = hrsp_pkg::CL_VERB;
        verb_cand = narrow_cand(0, 7, 7'h7f, 0, c);
        tok_pos = 1;
        phase = hrsp_pkg::PH_VERB;
      end
      hrsp_pkg::PH_VERB: if (!ws) begin
        r.cls = hrsp_pkg::CL_VERB;
        verb_cand = narrow_cand(0, 7, verb_cand, tok_pos, c);
        if (tok_pos < 31) tok_pos++;
      end else begin
        cur_verb = pick_code(0, 7, verb_cand, tok_pos);
        phase = hrsp_pkg::PH_ROUTE_SEEK;
      end
      hrsp_pkg::PH_ROUTE_SEEK: if (!ws) begin
        r.cls = hrsp_pkg::CL_ROUTE;
        phase = hrsp_pkg::PH_ROUTE;
      end
      hrsp_pkg::PH_ROUTE: if (!ws) r.cls = hrsp_pkg::CL_ROUTE;
        else begin
          phase = hrsp_pkg::PH_MARKER;
          mark_pos = 0;
        end
      hrsp_pkg::PH_MARKER: begin
        if (mark_pos < 5 && c == mark[mark_pos]) mark_pos++;
        else mark_pos = (c == "H") ? 3'd1 : 3'd0;
        if (mark_pos >= 5) begin
          mark_pos = 0;
          phase = hrsp_pkg::PH_VERSION;
          tok_pos = 0;
          ver_cand = 7'h1f;
        end
      end
      hrsp_pkg::PH_VERSION: if (!ws) begin
        r.cls = hrsp_pkg::CL_VERSION;
        ver_cand = narrow_cand(1, 5, ver_cand, tok_pos, c);
        if (tok_pos < 31) tok_pos++;
      end else begin
        cur_ver = pick_code(1, 5, ver_cand, tok_pos);
        phase = hrsp_pkg::PH_LINE_END;
      end
      hrsp_pkg::PH_LINE_END: if (c == 8'h0a) begin
        r.ev = hrsp_pkg::EV_LINE_DONE;
        phase = hrsp_pkg::PH_HDR_START;
      end
      hrsp_pkg::PH_HDR_START: if (c == 8'h0a) begin
        body_cnt = 0;
        if (frame_mode == hrsp_pkg::LM_LENGTH) begin
          r.ev = hrsp_pkg::EV_SIZE;
          if (size_acc == 0) begin
            r.done = 1;
            restart = 1;
          end else phase = hrsp_pkg::PH_BODY_LEN;
        end else begin
          r.ev = hrsp_pkg::EV_HDRS_END;
          size_acc = 0;
          hdr_flags = 0;
          phase = hrsp_pkg::PH_CH_SKIP;
        end
      end else if (!ws) begin
        r.cls = hrsp_pkg::CL_NAME;
        name_cand = narrow_cand(2, 6, 7'h3f, 0, up);
        tok_pos = 1;
        hdr_flags = 0;
        phase = hrsp_pkg::PH_HDR_NAME;
      end
      hrsp_pkg::PH_HDR_NAME: if (!ws && c != ":") begin
        r.cls = hrsp_pkg::CL_NAME;
        name_cand = narrow_cand(2, 6, name_cand, tok_pos, up);
        if (tok_pos < 31) tok_pos++;
      end else begin
        cur_name = pick_code(2, 6, name_cand, tok_pos);
        r.ev = hrsp_pkg::EV_NAME;
        hdr_flags = (c == ":") ? hrsp_pkg::FL_DELIM : 5'd0;
        // only the first content-length header frames the body
        if (cur_name == hrsp_pkg::FD_CONTENT_LENGTH && frame_mode == hrsp_pkg::LM_CHUNKED)
        begin
          frame_mode = hrsp_pkg::LM_LENGTH;
          hdr_flags |= hrsp_pkg::FL_ACC;
          size_acc = 0;
        end
        phase = hrsp_pkg::PH_HDR_VALUE;
      end
      hrsp_pkg::PH_HDR_VALUE: begin
        if (!(hdr_flags & hrsp_pkg::FL_DELIM) && c == ":") hdr_flags |= hrsp_pkg::FL_DELIM;
        else if (c == 8'h0a) begin
          r.ev = hrsp_pkg::EV_HDR_DONE;
          phase = hrsp_pkg::PH_HDR_START;
        end else if (!ws && !(hdr_flags & hrsp_pkg::FL_STARTED)) begin
          hdr_flags |= hrsp_pkg::FL_STARTED;
          take = 1;
        end else if ((hdr_flags & hrsp_pkg::FL_STARTED) &&
                     !(hdr_flags & hrsp_pkg::FL_ENDED)) begin
          if (!ws || c == 8'h20 || c == 8'h09) take = 1;
          else hdr_flags |= hrsp_pkg::FL_ENDED;
        end
        if (take) begin
          r.cls = hrsp_pkg::CL_VALUE;
          if (hdr_flags & hrsp_pkg::FL_ACC) begin
            if (c >= "0" && c <= "9") begin
              if (size_acc > (SIZE_MAX - (c - "0")) / 10) r.err = hrsp_pkg::ER_OVERFLOW;
              else size_acc = size_acc * 10 + (c - "0");
            end else r.err = hrsp_pkg::ER_BAD_DEC;
          end
        end
      end
      hrsp_pkg::PH_BODY_LEN: begin
        r.cls = hrsp_pkg::CL_BODY;
        body_cnt++;
        if (body_cnt >= size_acc) begin
          r.done = 1;
          restart = 1;
        end
      end
      hrsp_pkg::PH_CH_SKIP: if (!ws) begin
        d = hex_digit(c);
        if (d < 0) r.err = hrsp_pkg::ER_BAD_HEX;
        else begin
          size_acc = d;
          hdr_flags = 0;
          phase = hrsp_pkg::PH_CH_SIZE;
        end
      end
      hrsp_pkg::PH_CH_SIZE: if (!ws) begin
        if (!(hdr_flags & hrsp_pkg::FL_STOPPED)) begin
          d = hex_digit(c);
          if (d < 0) hdr_flags |= hrsp_pkg::FL_STOPPED;
          else if (size_acc > ((SIZE_MAX - d) >> 4)) r.err = hrsp_pkg::ER_OVERFLOW;
          else size_acc = (size_acc << 4) + d;
        end
      end else begin
        r.ev = hrsp_pkg::EV_SIZE;
        body_cnt = 0;
        phase = hrsp_pkg::PH_CH_LF;
      end
      hrsp_pkg::PH_CH_LF: if (c == 8'h0a)
        phase = (size_acc == 0) ? hrsp_pkg::PH_CH_TRAIL : hrsp_pkg::PH_CH_DATA;
      hrsp_pkg::PH_CH_DATA: begin
        r.cls = hrsp_pkg::CL_BODY;
        body_cnt++;
        if (body_cnt >= size_acc) phase = hrsp_pkg::PH_CH_TRAIL;
      end
      hrsp_pkg::PH_CH_TRAIL: if (c == 8'h0a) begin
        r.ev = hrsp_pkg::EV_CHUNK;
        if (size_acc == 0) begin
          r.done = 1;
          restart = 1;
        end else begin
          size_acc = 0;
          body_cnt = 0;
          hdr_flags = 0;
          phase = hrsp_pkg::PH_CH_SKIP;
        end
      end
      default: restart = 1;
    endcase
    // errors hide class and event and restart the parser
    if (r.err != hrsp_pkg::ER_NONE) begin
      r.cls = hrsp_pkg::CL_SKIP;
      r.ev = hrsp_pkg::EV_NONE;
      restart = 1;
    end
    r.b = c;
    r.meth = cur_verb;
    r.ver = cur_ver;
    r.fld = cur_name;
    r.len = size_acc[31:0];
    result_q = {result_q, r};
    if (restart) restart_parser();
  endtask

  // input monitor: every accepted request feeds the mirror
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) parse_byte(in_byte);
  end

  // result checker: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    parse_result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_byte, out_byte_class, out_event_code, out_method_code,
              out_protocol_version, out_field_code, out_body_length,
              out_request_done, out_error_code};
      if (result_q.size() == 0) begin
        failed = 1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result byte=%h", out_byte);
      end else begin
        want = result_q.pop_front();
        if (got !== want) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp b=%h cls=%0d ev=%0d m=%0d v=%0d f=%0d len=%0d dn=%0d er=%0d",
                     want.b, want.cls, want.ev, want.meth, want.ver, want.fld, want.len,
                     want.done, want.err,
                     "\n          got b=%h cls=%0d ev=%0d m=%0d v=%0d f=%0d len=%0d dn=%0d er=%0d",
                     got.b, got.cls, got.ev, got.meth, got.ver, got.fld, got.len,
                     got.done, got.err);
        end
      end
    end
  end

  // receiver: random stall bursts, plus a long hold-off when asked
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req = 0;
    end
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  // send one request byte; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // drains the stream, then drops valid and waits for a falling edge
  task automatic flush_stream();
    while (stream_q.size() > 0) send_byte(stream_q.pop_front());
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // random letter case, for the case-insensitive header names
  function automatic string mix_case(input string s);
    for (int i = 0; i < s.len(); i++)
      if (((s[i] >= "a" && s[i] <= "z") || (s[i] >= "A" && s[i] <= "Z")) && $urandom_range(0, 1))
        s[i] = s[i] ^ 8'h20;
    return s;
  endfunction

  function automatic string rand_token(input int n);
    string s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(8'h21, 8'h7e)))};
    return s;
  endfunction

  // one well-formed request with random content, sometimes corrupted
  task automatic build_request();
    string verbs[10] = '{"GET", "POST", "PATCH", "PUT", "TRACE", "DELETE", "CONNECT",
                         "GE", "POSTS", "get"};
    string vers[8] = '{"0.9", "1.0", "1.1", "2", "3", "1.2", "11", "2.0"};
    string names[8] = '{"Content-Type", "Accept", "Host", "Transfer-Encoding",
                        "Connection", "X-Custom", "Content", "Hosts"};
    int nhdr, len, nchunk, csize, first;
    bit use_len;
    first = stream_q.size();
    add_text({verbs[$urandom_range(0, 9)], " /", rand_token($urandom_range(0, 6)), " ",
              ($urandom_range(0, 5) == 0) ? "xHTTP/" : "HTTP/", vers[$urandom_range(0, 7)],
              "\r\n"});
    use_len = $urandom_range(0, 1);
    len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 24);
    nhdr = $urandom_range(0, 3);
    for (int h = 0; h <= nhdr; h++) begin
      if (h == nhdr / 2 && use_len)
        add_text({mix_case("Content-Length"), ":", ($urandom_range(0, 1) ? " " : ""),
                  $sformatf("%0d", len), "\r\n"});
      else if (h < nhdr)
        add_text({mix_case(names[$urandom_range(0, 7)]), ": ",
                  rand_token($urandom_range(1, 8)), "\r\n"});
    end
    add_text("\r\n");
    if (use_len) begin
      for (int i = 0; i < len; i++) add_byte($urandom_range(0, 255));
    end else begin
      nchunk = $urandom_range(0, 2);
      for (int k = 0; k < nchunk; k++) begin
        csize = $urandom_range(1, 20);
        add_text({($urandom_range(0, 1) ? $sformatf("%0h", csize) : $sformatf("0%0H", csize)),
                  ($urandom_range(0, 3) == 0) ? ";x=1" : "", "\r\n"});
        for (int i = 0; i < csize; i++) add_byte($urandom_range(0, 255));
        add_text("\r\n");
      end
      add_text("0\r\n\r\n");
    end
    // a few requests get one byte broken
    if ($urandom_range(0, 9) == 0)
      stream_q[$urandom_range(first, stream_q.size() - 1)] = $urandom_range(0, 255);
  endtask

  // a stray run of arbitrary bytes can leave the parser anywhere;
  // a known error afterwards brings it back to the request line
  task automatic add_resync();
    add_text("\r\nGET / HTTP/1.1\r\n\r\nz ");
  endtask

  task automatic test_directed();
    add_text("CONNECT / HTTP/1.1\r\nhost: a\r\ncontent-length: 0\r\n\r\n");
    add_text("TRACE /x HTTP/0.9\r\nCONTENT-LENGTH:   \r\n\r\n");
    add_text("DELETE /y HTTP/3\r\nContent-Length: 3\r\nContent-Length: 9\r\n\r\nabc");
    add_text("PUT / HTTP/2 \r\nContent-Length: 4294967296\r\n");
    add_text("GET / HTTP/1.0\r\nContent-Length: 12a\r\n");
    add_text("PATCH / HTTP/1.1\r\nTransfer-Encoding: chunked\r\n\r\nzz");
    add_text("POST / HTTP/1.1\r\n\r\n  100000000\r\n");
    add_text("GET / HTTP/1.1\r\n\r\nFFFFFFF\r\n");
    add_resync();
    add_text({"AAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAA HHTTP/", rand_token(40), "\r\n",
              "Content-LengthContent-LengthContent-Length: 1\r\n\r\n"});
    add_resync();
    add_text("GET /r HTTP/1.1\r\n\r\n3g9\r\nabc\r\n0\r\n\r\n");
    add_text({8'hff, 8'h80, 8'h00, "\n"});
    add_resync();
    flush_stream();
  endtask

  task automatic test_random_requests(input int goal);
    while (bytes_sent < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 20)) add_byte($urandom_range(0, 255));
        add_resync();
      end else build_request();
      flush_stream();
    end
  endtask

  task automatic test_backpressure();
    @(posedge clk);
    hold_req = 1;
    @(negedge clk);
    build_request();
    build_request();
    flush_stream();
  endtask

  task automatic test_full_rate(input int goal);
    tx_idle_on = 0;
    rx_idle_on = 0;
    test_random_requests(goal);
  endtask

  initial begin
    int waited;
    restart_parser();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_requests(700);
    test_backpressure();
    test_random_requests(950);
    test_full_rate(1150);
    waited = 0;
    while (result_q.size() > 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (5) @(posedge clk);
    if (failed || result_q.size() > 0) $display("tb: failure");
    else $display("tb: success");
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
